// File: rtl/core/double_ended_queue_unit_macros.svh
// assertion helpers shared by the deque unit
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/deq_pkg.sv
package deq_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 11;
  localparam int unsigned OccW  = 11;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_FRONT      = 3'd4,
    OP_BACK       = 3'd5,
    OP_READ_AT    = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  // broadcast shift control for the word chain
  typedef struct packed {
    logic shift_in;   // every word moves one cell back, new word at cell 0
    logic shift_out;  // every word moves one cell toward cell 0
    logic append;     // cell matching the count takes the new word
  } cell_ctl_t;

endpackage

// File: rtl/core/deq_cell.sv
module deq_cell
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned INDEX = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cell_ctl_t                        ctl_i,
  input  logic [$clog2(DEPTH+1)-1:0]       count_i,
  input  logic signed [WordW-1:0]          value_i,
  input  logic signed [WordW-1:0]          left_word_i,
  input  logic signed [WordW-1:0]          right_word_i,
  output logic signed [WordW-1:0]          word_o,
  input  logic                             req_valid_i,
  input  logic [$clog2(DEPTH)-1:0]         req_cnt_i,
  output logic                             req_valid_o,
  output logic [$clog2(DEPTH)-1:0]         req_cnt_o,
  input  logic                             rep_valid_i,
  input  logic signed [WordW-1:0]          rep_data_i,
  output logic                             rep_valid_o,
  output logic signed [WordW-1:0]          rep_data_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  logic signed [WordW-1:0] word_q, word_d;
  logic                    req_valid_q, req_valid_d;
  logic [AW-1:0]           req_cnt_q, req_cnt_d;
  logic                    rep_valid_q, rep_valid_d;
  logic signed [WordW-1:0] rep_data_q, rep_data_d;
  logic                    hit;

  always_comb begin
    word_d = word_q;
    if (ctl_i.shift_in) begin
      word_d = left_word_i;
    end else if (ctl_i.shift_out) begin
      word_d = right_word_i;
    end else if (ctl_i.append && (count_i == CW'(INDEX))) begin
      word_d = value_i;
    end
  end

  // read token walks back until its count runs out, reply walks home
  assign hit         = req_valid_i && (req_cnt_i == '0);
  assign req_valid_d = req_valid_i && (req_cnt_i != '0);
  assign req_cnt_d   = req_cnt_i - AW'(1);
  assign rep_valid_d = hit ? 1'b1 : rep_valid_i;
  assign rep_data_d  = hit ? word_q : rep_data_i;

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    req_cnt_q  <= req_cnt_d;
    rep_data_q <= rep_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rep_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      rep_valid_q <= rep_valid_d;
    end
  end

  assign word_o      = word_q;
  assign req_valid_o = req_valid_q;
  assign req_cnt_o   = req_cnt_q;
  assign rep_valid_o = rep_valid_q;
  assign rep_data_o  = rep_data_q;

endmodule

// File: rtl/core/double_ended_queue_unit.sv
// bounded double-ended queue of signed 32-bit words, one word per cell
// command channel: start/busy; an item is taken on a rising edge with start
// high and busy low, carrying opcode_i, value_i and position_i
// result channel: done_o marks one cycle carrying status_o, read_data_o,
// data_valid_o and occupancy_o; the receiver cannot stall, so every result
// is taken at the edge that ends its cycle
// push, pop, failed commands and the unused opcode: result in the cycle
// after the accept edge, busy stays low, one item per cycle
// front, back, read_at that succeed: a read token walks down the cell row
// and the word walks back, so a read at a deeper offset takes longer; busy
// is high from the accept edge until the result shows, and the next item
// can be taken at the edge that ends the result cycle
// front pushes and pops shift the whole row by one cell at the accept edge;
// a back push writes the cell at the count, a back pop only drops the count
// reset clears the count, the read tokens and the result strobe; cell
// contents are left as they are and only live cells are ever read
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              opcode_i,
  input  logic signed [WordW-1:0] value_i,
  input  logic [PosW-1:0]         position_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic signed [WordW-1:0] read_data_o,
  output logic                    data_valid_o,
  output logic [OccW-1:0]         occupancy_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  // common width for count / position compares and the occupancy field
  localparam int unsigned LW = (CW > PosW) ? CW : PosW;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e                  state_q;
  logic [CW-1:0]           count_q, count_d;
  logic                    done_q;
  status_e                 status_q, status_d;
  logic signed [WordW-1:0] rdata_q;
  logic                    dvalid_q;

  logic                    accept;
  logic                    read_go;
  logic [AW-1:0]           read_off;
  cell_ctl_t               ctl;
  logic [LW-1:0]           count_ext, pos_ext;
  logic                    empty, full;

  // cell row wiring
  logic signed [WordW-1:0] words   [DEPTH];
  logic                    req_v   [DEPTH];
  logic [AW-1:0]           req_c   [DEPTH];
  logic                    rep_v   [DEPTH];
  logic signed [WordW-1:0] rep_d   [DEPTH];

  assign busy      = (state_q == ST_READ);
  assign accept    = start && !busy;
  assign count_ext = LW'(count_q);
  assign pos_ext   = LW'(position_i);
  assign empty     = (count_q == '0);
  assign full      = (count_q == CW'(DEPTH));

  // command decode: status, new count, row shift and read token
  always_comb begin
    status_d = STATUS_OK;
    count_d  = count_q;
    ctl      = '0;
    read_go  = 1'b0;
    read_off = '0;
    if (accept) begin
      case (opcode_e'(opcode_i))
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            ctl.append = 1'b1;
            count_d    = count_q + CW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            ctl.shift_in = 1'b1;
            count_d      = count_q + CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            count_d = count_q - CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            ctl.shift_out = 1'b1;
            count_d       = count_q - CW'(1);
          end
        end
        OP_FRONT: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            read_go = 1'b1;
          end
        end
        OP_BACK: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            read_go  = 1'b1;
            read_off = AW'(count_q - CW'(1));
          end
        end
        OP_READ_AT: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else if ((pos_ext == '0) || (pos_ext > count_ext)) begin
            status_d = STATUS_RANGE;
          end else begin
            read_go  = 1'b1;
            read_off = AW'(pos_ext - LW'(1));
          end
        end
        default: begin
          // unused opcode: no effect
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WordW-1:0] left_w, right_w;
    logic                    rq_v_in, rp_v_in;
    logic [AW-1:0]           rq_c_in;
    logic signed [WordW-1:0] rp_d_in;

    if (i == 0) begin : g_head
      assign left_w  = value_i;
      assign rq_v_in = read_go;
      assign rq_c_in = read_off;
    end else begin : g_body
      assign left_w  = words[i-1];
      assign rq_v_in = req_v[i-1];
      assign rq_c_in = req_c[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_w = words[i];
      assign rp_v_in = 1'b0;
      assign rp_d_in = '0;
    end else begin : g_inner
      assign right_w = words[i+1];
      assign rp_v_in = rep_v[i+1];
      assign rp_d_in = rep_d[i+1];
    end

    deq_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .count_i      (count_q),
      .value_i      (value_i),
      .left_word_i  (left_w),
      .right_word_i (right_w),
      .word_o       (words[i]),
      .req_valid_i  (rq_v_in),
      .req_cnt_i    (rq_c_in),
      .req_valid_o  (req_v[i]),
      .req_cnt_o    (req_c[i]),
      .rep_valid_i  (rp_v_in),
      .rep_data_i   (rp_d_in),
      .rep_valid_o  (rep_v[i]),
      .rep_data_o   (rep_d[i])
    );
  end

  // control state and the registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= STATUS_OK;
      rdata_q  <= '0;
      dvalid_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            count_q <= count_d;
            if (read_go) begin
              state_q <= ST_READ;
            end else begin
              // immediate result for everything but a live read
              done_q   <= 1'b1;
              status_q <= status_d;
              rdata_q  <= '0;
              dvalid_q <= 1'b0;
            end
          end
        end
        ST_READ: begin
          // word is back at the head cell
          if (rep_v[0]) begin
            state_q  <= ST_IDLE;
            done_q   <= 1'b1;
            status_q <= STATUS_OK;
            rdata_q  <= rep_d[0];
            dvalid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_data_o  = rdata_q;
  assign data_valid_o = dvalid_q;
  assign occupancy_o  = count_ext[OccW-1:0];

  // the count never runs past the row length
  `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "count above depth")
  // a reply reaches the head cell only while a read is outstanding
  `DEQ_ASSERT_NOW(a_reply_owned, rep_v[0], state_q == ST_READ, "stray read reply")
  // a live read holds the command side off on the next cycle
  `DEQ_ASSERT_NEXT(a_read_busy, read_go, busy && !done_o, "read not holding busy")
  // a valid word is only ever reported with an ok status
  `DEQ_ASSERT_NOW(a_valid_ok, done_o && data_valid_o, status_q == STATUS_OK, "bad status")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import deq_pkg::*;

  localparam int unsigned DEPTH = 1024;

  // random part: about this many items, with one fill-to-full episode in it
  localparam int unsigned RandomItems = 2000;
  localparam int unsigned FillAt      = 400;

  // sized to be several times the slowest correct run, even if every item
  // were a read at the deepest offset with sender gaps on top
  localparam int unsigned CycleLimit  = 25_000_000;

  // unused opcode, not part of the package enum
  localparam logic [2:0]  OpUnused    = 3'd7;

  typedef struct {
    status_e          status;
    logic [WordW-1:0] data;
    logic             valid;
    logic [OccW-1:0]  occ;
  } deq_result_t;

  // how the random part mixes commands
  typedef enum {
    MIX_SMALL,  // short queue drifting around a moving target length
    MIX_FILL,   // mostly pushes until the ring is full
    MIX_FULL,   // a few items while full: failing pushes, deep reads
    MIX_DRAIN   // mostly pops back down to a short queue
  } mix_e;

  // predicted deque: ring contents, front slot, live count, and the
  // results still owed by the block in order
  class deque_scoreboard;
    logic [WordW-1:0] words [DEPTH];
    int unsigned      head;
    int unsigned      count;
    deq_result_t      owed_q [$];
    int unsigned      errors;

    function new();
      head   = 0;
      count  = 0;
      errors = 0;
    endfunction

    function int unsigned slot(int unsigned off);
      return (head + off) % DEPTH;
    endfunction

    function void note_cmd(logic [2:0] op, logic [WordW-1:0] val, logic [PosW-1:0] pos);
      deq_result_t r;
      int unsigned off;
      r.status = STATUS_OK;
      r.data   = '0;
      r.valid  = 1'b0;
      case (op)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (count >= DEPTH) begin
            r.status = STATUS_FULL;
          end else if (op == OP_PUSH_BACK) begin
            words[slot(count)] = val;
            count++;
          end else begin
            head = (head == 0) ? DEPTH - 1 : head - 1;
            words[head] = val;
            count++;
          end
        end
        OP_POP_BACK, OP_POP_FRONT: begin
          if (count == 0) begin
            r.status = STATUS_EMPTY;
          end else begin
            if (op == OP_POP_FRONT) head = slot(1);
            count--;
          end
        end
        OP_FRONT, OP_BACK, OP_READ_AT: begin
          if (count == 0) begin
            r.status = STATUS_EMPTY;
          end else if (op == OP_READ_AT && (pos == 0 || pos > count)) begin
            r.status = STATUS_RANGE;
          end else begin
            if (op == OP_FRONT) off = 0;
            else if (op == OP_BACK) off = count - 1;
            else off = pos - 1;
            r.data  = words[slot(off)];
            r.valid = 1'b1;
          end
        end
        default: ;
      endcase
      r.occ = OccW'(count);
      owed_q = {owed_q, r};
    endfunction

    function void check_result(logic [1:0] st, logic [WordW-1:0] data, logic valid,
                               logic [OccW-1:0] occ);
      deq_result_t e;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: result with no command outstanding", $time,
                 " (status=%0d data=%h valid=%b occ=%0d)", st, data, valid, occ);
        return;
      end
      e = owed_q[0];
      owed_q.delete(0);
      if ({st, data, valid, occ} !== {e.status, e.data, e.valid, e.occ}) begin
        errors++;
        $display("%0t: mismatch exp status=%0d data=%h valid=%b occ=%0d",
                 $time, e.status, e.data, e.valid, e.occ,
                 " got status=%0d data=%h valid=%b occ=%0d", st, data, valid, occ);
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [2:0]              opcode_i;
  logic signed [WordW-1:0] value_i;
  logic [PosW-1:0]         position_i;
  logic                    done_o;
  logic [1:0]              status_o;
  logic signed [WordW-1:0] read_data_o;
  logic                    data_valid_o;
  logic [OccW-1:0]         occupancy_o;

  deque_scoreboard sb = new();

  int unsigned idle_pct;      // chance in percent of a gap cycle before an item
  mix_e        mix;
  int unsigned full_left;     // items still to send while the ring is full
  int unsigned small_target;  // length the short queue drifts toward
  int unsigned cycles = 0;

  double_ended_queue_unit #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .read_data_o (read_data_o),
    .data_valid_o(data_valid_o),
    .occupancy_o (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // results cannot be held off: every strobed cycle is one result
  // outputs are read at the edge, before the block updates them
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) begin
      sb.check_result(status_o, read_data_o, data_valid_o, occupancy_o);
    end
  end

  // called right after a rising edge; returns after the edge that took the
  // item once busy is low, so a following item keeps start high without a dip
  task automatic send_cmd(input logic [2:0] op, input logic [WordW-1:0] val,
                          input logic [PosW-1:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      // gap cycle: start low, payload scrambled
      start      <= 1'b0;
      opcode_i   <= 3'($urandom);
      value_i    <= $urandom;
      position_i <= PosW'($urandom);
      @(posedge clk_i);
    end
    start      <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    position_i <= pos;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sb.note_cmd(op, val, pos);
  endtask

  // picks the next random item from the predicted state and the current mix
  task automatic next_random_cmd(output logic [2:0] op, output logic [WordW-1:0] val,
                                 output logic [PosW-1:0] pos);
    int unsigned roll;
    int unsigned cnt;
    int unsigned push_pct;
    int unsigned lim;
    cnt = sb.count;

    // mix transitions follow the predicted length
    if (mix == MIX_FILL && cnt == DEPTH) begin
      mix       = MIX_FULL;
      full_left = 12;
    end else if (mix == MIX_FULL) begin
      if (full_left == 0) mix = MIX_DRAIN;
      else full_left--;
    end else if (mix == MIX_DRAIN && cnt < 16) begin
      mix = MIX_SMALL;
    end
    if ($urandom_range(49) == 0) small_target = $urandom_range(40);

    // words: extremes now and then, otherwise anything
    case ($urandom_range(9))
      0:       val = 32'h7fff_ffff;
      1:       val = 32'h8000_0000;
      2:       val = 32'h0000_0000;
      3:       val = 32'hffff_ffff;
      default: val = $urandom;
    endcase
    pos  = PosW'($urandom);
    roll = $urandom_range(99);

    case (mix)
      MIX_SMALL: begin
        push_pct = (cnt < small_target) ? 45 : 20;
        if (roll < 5) op = OpUnused;
        else if (roll < 5 + push_pct) op = OP_PUSH_BACK + 3'($urandom_range(1));
        else if (roll < 75) op = OP_POP_BACK + 3'($urandom_range(1));
        else op = OP_FRONT + 3'($urandom_range(2));
      end
      MIX_FILL: begin
        if (roll < 90) op = OP_PUSH_BACK + 3'($urandom_range(1));
        else if (roll < 93) op = OP_POP_BACK + 3'($urandom_range(1));
        else op = OP_FRONT + 3'($urandom_range(2));
      end
      MIX_FULL: begin
        if (roll < 55) op = OP_PUSH_BACK + 3'($urandom_range(1));
        else if (roll < 65) op = OP_POP_BACK + 3'($urandom_range(1));
        else op = OP_FRONT + 3'($urandom_range(2));
      end
      default: begin
        if (roll < 88) op = OP_POP_BACK + 3'($urandom_range(1));
        else if (roll < 92) op = OP_PUSH_BACK + 3'($urandom_range(1));
        else op = OP_FRONT + 3'($urandom_range(2));
      end
    endcase

    // read_at positions: mostly live, some just outside, some anything
    if (op == OP_READ_AT) begin
      case ($urandom_range(9))
        0: pos = '0;
        1: pos = PosW'(cnt + 1);
        2: pos = PosW'($urandom);
        3: pos = $urandom_range(1) ? PosW'(1024) : PosW'(2047);
        default: begin
          // long queues read near the front to keep reads short
          lim = (mix == MIX_SMALL) ? cnt : ((cnt < 16) ? cnt : 16);
          pos = (cnt == 0) ? PosW'(1) : PosW'($urandom_range(lim, 1));
        end
      endcase
      // while full, also the very last word
      if (mix == MIX_FULL && $urandom_range(3) == 0) pos = PosW'(DEPTH);
    end
  endtask

  initial begin
    int unsigned      n;
    logic [2:0]       op;
    logic [WordW-1:0] val;
    logic [PosW-1:0]  pos;

    idle_pct     = 0;
    mix          = MIX_SMALL;
    full_left    = 0;
    small_target = 8;
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    opcode_i   <= OP_PUSH_BACK;
    value_i    <= '0;
    position_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: everything on an empty queue first
    send_cmd(OP_POP_BACK,  32'h1234_5678, 11'd1);
    send_cmd(OP_POP_FRONT, 32'h0,         11'd1);
    send_cmd(OP_FRONT,     32'h0,         11'd1);
    send_cmd(OP_BACK,      32'h0,         11'd1);
    send_cmd(OP_READ_AT,   32'h0,         11'd1);
    send_cmd(OP_READ_AT,   32'h0,         11'd0);
    send_cmd(OpUnused,     32'hdead_beef, 11'd2047);
    // extreme words from both ends: -1, min, max, 0 from the front
    send_cmd(OP_PUSH_BACK,  32'h7fff_ffff, 11'd0);
    send_cmd(OP_PUSH_FRONT, 32'h8000_0000, 11'd0);
    send_cmd(OP_PUSH_BACK,  32'h0000_0000, 11'd0);
    send_cmd(OP_PUSH_FRONT, 32'hffff_ffff, 11'd0);
    send_cmd(OP_FRONT,      32'h0, 11'd0);
    send_cmd(OP_BACK,       32'h0, 11'd0);
    send_cmd(OP_READ_AT,    32'h0, 11'd1);
    send_cmd(OP_READ_AT,    32'h0, 11'd4);
    // position zero, one past the end, the field maximum
    send_cmd(OP_READ_AT,    32'h0, 11'd0);
    send_cmd(OP_READ_AT,    32'h0, 11'd5);
    send_cmd(OP_READ_AT,    32'h0, 11'd2047);
    send_cmd(OpUnused,      32'hffff_ffff, 11'd3);
    // pops do not report the word, then drain past empty
    send_cmd(OP_POP_FRONT,  32'h0, 11'd0);
    send_cmd(OP_POP_BACK,   32'h0, 11'd0);
    send_cmd(OP_READ_AT,    32'h0, 11'd2);
    send_cmd(OP_POP_BACK,   32'h0, 11'd0);
    send_cmd(OP_POP_FRONT,  32'h0, 11'd0);
    send_cmd(OP_POP_BACK,   32'h0, 11'd0);

    // random part; sender gap rate steps 31%, 76%, then none
    n = 0;
    while (n < RandomItems) begin
      if (n == FillAt) mix = MIX_FILL;
      idle_pct = (n < 700) ? 31 : ((n < 1400) ? 76 : 0);
      next_random_cmd(op, val, pos);
      send_cmd(op, val, pos);
      n++;
    end
    start <= 1'b0;

    // every item owes one result; then a short quiet tail
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
